// ===== hw/rtl/tsprt_pkg.sv =====
`timescale 1ns / 1ps
// Package of the transport stream PES reassembly tracker.
// Holds table sizes, codes and the context, packet and descriptor types.
package tsprt_pkg;

	localparam int NUM_PIDS     = 8192;
	localparam int PID_AW       = $clog2(NUM_PIDS);
	localparam int HDR_BYTES    = 6;
	localparam int PREFIX_BYTES = 3;
	localparam logic [23:0] BYTES_MAX = 24'hFFFFFF;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic [1:0] CAUSE_LENGTH = 2'd0;
	localparam logic [1:0] CAUSE_UNIT   = 2'd1;
	localparam logic [1:0] CAUSE_FLUSH  = 2'd2;

	// One entry of the per-PID context table.
	typedef struct packed {
		logic        valid;
		logic        sync;
		logic [3:0]  last_cc;
		logic [23:0] bytes;
		logic [47:0] header;
		logic [31:0] first_idx;
		logic [31:0] last_idx;
		logic [41:0] pcr;
		logic        pcr_valid;
	} ctx_t;

	// One accepted input transaction.
	typedef struct packed {
		logic        op;
		logic [12:0] pid;
		logic        sync_ok;
		logic        unit_start;
		logic [3:0]  cc;
		logic        scrambled;
		logic [7:0]  size;
		logic [47:0] head;
		logic        has_pcr;
		logic [41:0] pcr;
		logic [31:0] index;
	} pkt_t;

	// One completion descriptor.
	typedef struct packed {
		logic [12:0] pid;
		logic [31:0] first_index;
		logic [31:0] last_index;
		logic        pcr_valid;
		logic [41:0] pcr;
		logic [23:0] byte_count;
		logic [1:0]  end_cause;
		logic        last_in_run;
	} desc_t;

endpackage

// ===== hw/rtl/tsprt_update.sv =====
`timescale 1ns / 1ps
// Context update of the PES reassembly tracker: next table entry and descriptors.
// Depends on tsprt_pkg.
module tsprt_update import tsprt_pkg::*; (
	input  pkt_t        pkt,
	input  ctx_t        cur,
	output ctx_t        nxt,
	output desc_t       desc0,
	output desc_t       desc1,
	output logic [1:0]  n_out
);

	// Build a descriptor from a context entry.
	function automatic desc_t mk_desc(ctx_t c, logic [12:0] pid, logic [1:0] cause);
		desc_t d;
		d.pid         = pid;
		d.first_index = c.first_idx;
		d.last_index  = c.last_idx;
		d.pcr_valid   = c.pcr_valid;
		d.pcr         = c.pcr_valid ? c.pcr : 42'd0;
		d.byte_count  = c.bytes;
		d.end_cause   = cause;
		d.last_in_run = 1'b0;
		return d;
	endfunction

	// Fill header byte positions not yet held from the head of this packet.
	function automatic logic [47:0] merge_hdr(logic [47:0] hdr, logic [23:0] bytes,
			logic [47:0] head, logic [7:0] size);
		logic [47:0] h;
		int pos;
		int i;
		h = hdr;
		pos = (bytes >= 24'(HDR_BYTES)) ? HDR_BYTES : int'(bytes[2:0]);
		for (int j = 0; j < HDR_BYTES; j++) begin
			i = j - pos;
			if (j >= pos && i < int'(size)) begin
				h[47 - 8 * j -: 8] = head[47 - 8 * i -: 8];
			end
		end
		return h;
	endfunction

	function automatic logic [23:0] sat_add(logic [23:0] bytes, logic [7:0] size);
		logic [24:0] s;
		s = {1'b0, bytes} + 25'(size);
		return s[24] ? BYTES_MAX : s[23:0];
	endfunction

	// PES length reached once the six header bytes are held and the declared length is nonzero.
	function automatic logic is_complete(ctx_t c);
		logic [24:0] need;
		need = 25'(c.header[15:0]) + 25'(HDR_BYTES);
		return c.sync && (c.bytes >= 24'(HDR_BYTES)) && (c.header[15:0] != 16'd0)
			&& ({1'b0, c.bytes} >= need);
	endfunction

	desc_t da;
	desc_t db;
	logic  emit_a;
	logic  emit_b;
	logic  check;

	// Decide the new entry and any descriptors.
	always_comb begin
		nxt    = cur;
		emit_a = 1'b0;
		emit_b = 1'b0;
		check  = 1'b0;
		da     = mk_desc(cur, pkt.pid, CAUSE_FLUSH);
		if (pkt.op == OP_FLUSH) begin
			if (cur.valid && cur.sync && cur.bytes != 24'd0) begin
				emit_a    = 1'b1;
				nxt.sync  = 1'b0;
				nxt.bytes = 24'd0;
			end
		end else if (pkt.sync_ok && (cur.valid || pkt.unit_start)) begin
			if (pkt.unit_start && cur.valid && cur.sync && cur.bytes != 24'd0) begin
				emit_a       = 1'b1;
				da.end_cause = CAUSE_UNIT;
				nxt.sync     = 1'b0;
				nxt.bytes    = 24'd0;
			end
			if (pkt.scrambled) begin
				nxt.valid = 1'b0;
				nxt.sync  = 1'b0;
			end else if (pkt.unit_start) begin
				if (pkt.size >= 8'(PREFIX_BYTES) && pkt.head[47:24] == 24'h000001) begin
					nxt.valid     = 1'b1;
					nxt.sync      = 1'b1;
					nxt.last_cc   = pkt.cc;
					nxt.header    = merge_hdr(48'd0, 24'd0, pkt.head, pkt.size);
					nxt.bytes     = sat_add(24'd0, pkt.size);
					nxt.first_idx = pkt.index;
					nxt.last_idx  = pkt.index;
					nxt.pcr       = pkt.has_pcr ? pkt.pcr : 42'd0;
					nxt.pcr_valid = pkt.has_pcr;
					check         = 1'b1;
				end else begin
					nxt.valid = 1'b0;
					nxt.sync  = 1'b0;
				end
			end else if (cur.sync && pkt.cc != cur.last_cc) begin
				if (pkt.cc != cur.last_cc + 4'd1) begin
					nxt.sync  = 1'b0;
					nxt.bytes = 24'd0;
				end else begin
					nxt.last_cc  = pkt.cc;
					nxt.header   = merge_hdr(cur.header, cur.bytes, pkt.head, pkt.size);
					nxt.bytes    = sat_add(cur.bytes, pkt.size);
					nxt.last_idx = pkt.index;
					if (!cur.pcr_valid && pkt.has_pcr) begin
						nxt.pcr       = pkt.pcr;
						nxt.pcr_valid = 1'b1;
					end
					check = 1'b1;
				end
			end
		end
		db = mk_desc(nxt, pkt.pid, CAUSE_LENGTH);
		if (check && is_complete(nxt)) begin
			emit_b    = 1'b1;
			nxt.sync  = 1'b0;
			nxt.bytes = 24'd0;
		end
	end

	// Order the descriptors and mark the final one.
	always_comb begin
		desc0 = da;
		desc1 = db;
		n_out = 2'd0;
		if (emit_a && emit_b) begin
			desc1.last_in_run = 1'b1;
			n_out = 2'd2;
		end else if (emit_a) begin
			desc0.last_in_run = 1'b1;
			n_out = 2'd1;
		end else if (emit_b) begin
			desc0 = db;
			desc0.last_in_run = 1'b1;
			n_out = 2'd1;
		end
	end

endmodule

// ===== hw/rtl/ts_pes_reassembly_tracker_top.sv =====
`timescale 1ns / 1ps
// Top level of the transport stream PES reassembly tracker. Uses tsprt_pkg, tsprt_update.
// Each input is read from the table, then updated and written back; its descriptors are
// registered into the output queue at the write back, which waits until the two-entry
// output queue has drained. A new input is taken while results wait, after the write back.
// Reset: asynchronous; the context table is then cleared one entry a cycle, all 8192 entries,
// during which no input is accepted.
module ts_pes_reassembly_tracker_top import tsprt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [12:0] pid,
	input  logic        sync_ok,
	input  logic        unit_start,
	input  logic [3:0]  cc,
	input  logic        scrambled,
	input  logic [7:0]  payload_size,
	input  logic [47:0] payload_head,
	input  logic        has_pcr,
	input  logic [41:0] pcr_in,
	input  logic [31:0] packet_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [12:0] done_pid,
	output logic [31:0] first_index,
	output logic [31:0] last_index,
	output logic        pcr_valid,
	output logic [41:0] pcr,
	output logic [23:0] byte_count,
	output logic [1:0]  end_cause,
	output logic        last_in_run
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0]        state_q;
	logic [PID_AW-1:0] clr_q;
	pkt_t              pkt_q;
	logic              in_range_q;
	ctx_t              rd_s1;
	ctx_t              ctx_mem [NUM_PIDS];
	ctx_t              nxt;
	desc_t             desc0;
	desc_t             desc1;
	logic [1:0]        n_out;
	desc_t             slot0_q;
	desc_t             slot1_q;
	logic [1:0]        cnt_q;
	logic              in_acc;
	logic              out_acc;
	logic              go;
	logic              we;
	logic [PID_AW-1:0] waddr;
	ctx_t              wdata;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_acc  = out_valid && out_ready;
	assign go       = (state_q == S_EXEC) && (cnt_q == 2'd0);

	tsprt_update u_update (
		.pkt   (pkt_q),
		.cur   (rd_s1),
		.nxt   (nxt),
		.desc0 (desc0),
		.desc1 (desc1),
		.n_out (n_out)
	);

	// Write port: clearing pass after reset, otherwise the updated entry.
	always_comb begin
		we    = (state_q == S_CLEAR) || (go && in_range_q);
		waddr = (state_q == S_CLEAR) ? clr_q : pkt_q.pid[PID_AW-1:0];
		wdata = (state_q == S_CLEAR) ? '0 : nxt;
	end

	// Context table with registered read data, read once per accepted transaction.
	always_ff @(posedge clk) begin
		if (we) begin
			ctx_mem[waddr] <= wdata;
		end
		if (in_acc) begin
			rd_s1 <= ctx_mem[pid[PID_AW-1:0]];
		end
	end

	// Capture the accepted input transaction.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pkt_q      <= '{op, pid, sync_ok, unit_start, cc, scrambled, payload_size,
				payload_head, has_pcr, pcr_in, packet_index};
			in_range_q <= ({1'b0, pid} < 14'(NUM_PIDS));
		end
	end

	// Sequencer: clearing pass, idle, update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PID_AW'(NUM_PIDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output queue of up to two descriptors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (go && in_range_q) begin
			cnt_q <= n_out;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			slot0_q <= desc0;
			slot1_q <= desc1;
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end
	end

	assign done_pid    = slot0_q.pid;
	assign first_index = slot0_q.first_index;
	assign last_index  = slot0_q.last_index;
	assign pcr_valid   = slot0_q.pcr_valid;
	assign pcr         = slot0_q.pcr;
	assign byte_count  = slot0_q.byte_count;
	assign end_cause   = slot0_q.end_cause;
	assign last_in_run = slot0_q.last_in_run;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the transport stream PES reassembly tracker.
// Depends on tsprt_pkg and ts_pes_reassembly_tracker_top; predicts descriptors per PID.
module testbench;
	import tsprt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [12:0] pid = '0;
	logic        sync_ok = 1'b0;
	logic        unit_start = 1'b0;
	logic [3:0]  cc = '0;
	logic        scrambled = 1'b0;
	logic [7:0]  payload_size = '0;
	logic [47:0] payload_head = '0;
	logic        has_pcr = 1'b0;
	logic [41:0] pcr_in = '0;
	logic [31:0] packet_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [12:0] done_pid;
	logic [31:0] first_index;
	logic [31:0] last_index;
	logic        pcr_valid;
	logic [41:0] pcr;
	logic [23:0] byte_count;
	logic [1:0]  end_cause;
	logic        last_in_run;

	ts_pes_reassembly_tracker_top DUT (.*);

	always #10 clk = ~clk;

	// Predicted context table, one entry per PID.
	ctx_t  pes_ctx [NUM_PIDS];
	pkt_t  pending_pkts [$];
	desc_t due_descs [$];
	int    errors = 0;
	bit    stim_done = 0;
	bit    calm = 0;
	bit    hold_req = 0;
	bit    hold_taken = 0;
	int    hold_off = 0;
	int    in_gap = 0;
	int    out_gap = 0;
	int    quiet = 0;
	pkt_t  t_drv;
	logic  in_ready_s = 1'b0;

	// Stream generator state for well-formed sequences, indexed by the low four PID bits.
	logic [3:0]  gen_cc [16];
	logic [31:0] pkt_count = 0;

	// Emit a descriptor for the given PID and drop its sync.
	function automatic void close_pes(input logic [12:0] p, input logic [1:0] why);
		desc_t d;
		d.pid = p;
		d.first_index = pes_ctx[p].first_idx;
		d.last_index = pes_ctx[p].last_idx;
		d.pcr_valid = pes_ctx[p].pcr_valid;
		d.pcr = pes_ctx[p].pcr_valid ? pes_ctx[p].pcr : '0;
		d.byte_count = pes_ctx[p].bytes;
		d.end_cause = why;
		d.last_in_run = 1'b0;
		due_descs.push_back(d);
		pes_ctx[p].sync = 1'b0;
		pes_ctx[p].bytes = '0;
	endfunction

	// Fill header bytes not yet held, then add the payload with saturation.
	function automatic void append_payload(input logic [12:0] p, input logic [47:0] hd,
			input logic [7:0] sz);
		int pos;
		int i;
		logic [24:0] sum;
		pos = pes_ctx[p].bytes < HDR_BYTES ? int'(pes_ctx[p].bytes) : HDR_BYTES;
		i = 0;
		while (pos < HDR_BYTES && i < int'(sz) && i < HDR_BYTES) begin
			pes_ctx[p].header[40 - 8 * pos +: 8] = hd[40 - 8 * i +: 8];
			pos++;
			i++;
		end
		sum = 25'(pes_ctx[p].bytes) + 25'(sz);
		pes_ctx[p].bytes = sum > 25'(BYTES_MAX) ? BYTES_MAX : sum[23:0];
	endfunction

	function automatic void check_length(input logic [12:0] p);
		if (pes_ctx[p].sync && pes_ctx[p].bytes >= HDR_BYTES &&
				pes_ctx[p].header[15:0] != 0 &&
				pes_ctx[p].bytes >= HDR_BYTES + pes_ctx[p].header[15:0])
			close_pes(p, CAUSE_LENGTH);
	endfunction

	// Predict the descriptors caused by one accepted transaction.
	function automatic void predict_descs(input pkt_t t);
		int n0;
		logic [12:0] p;
		n0 = due_descs.size();
		p = t.pid;
		if (t.op == OP_FLUSH) begin
			if (pes_ctx[p].valid && pes_ctx[p].sync && pes_ctx[p].bytes > 0)
				close_pes(p, CAUSE_FLUSH);
		end else if (t.sync_ok && (pes_ctx[p].valid || t.unit_start)) begin
			if (t.unit_start && pes_ctx[p].valid && pes_ctx[p].sync && pes_ctx[p].bytes > 0)
				close_pes(p, CAUSE_UNIT);
			if (t.scrambled) begin
				pes_ctx[p].valid = 1'b0;
				pes_ctx[p].sync = 1'b0;
			end else if (t.unit_start) begin
				if (t.size >= PREFIX_BYTES && t.head[47:24] == 24'h000001) begin
					pes_ctx[p].valid = 1'b1;
					pes_ctx[p].sync = 1'b1;
					pes_ctx[p].last_cc = t.cc;
					pes_ctx[p].bytes = '0;
					pes_ctx[p].header = '0;
					append_payload(p, t.head, t.size);
					pes_ctx[p].first_idx = t.index;
					pes_ctx[p].last_idx = t.index;
					pes_ctx[p].pcr = t.has_pcr ? t.pcr : '0;
					pes_ctx[p].pcr_valid = t.has_pcr;
					check_length(p);
				end else begin
					pes_ctx[p].valid = 1'b0;
					pes_ctx[p].sync = 1'b0;
				end
			end else if (pes_ctx[p].sync && t.cc != pes_ctx[p].last_cc) begin
				if (t.cc != pes_ctx[p].last_cc + 4'd1) begin
					pes_ctx[p].sync = 1'b0;
					pes_ctx[p].bytes = '0;
				end else begin
					pes_ctx[p].last_cc = t.cc;
					append_payload(p, t.head, t.size);
					pes_ctx[p].last_idx = t.index;
					if (!pes_ctx[p].pcr_valid && t.has_pcr) begin
						pes_ctx[p].pcr = t.pcr;
						pes_ctx[p].pcr_valid = 1'b1;
					end
					check_length(p);
				end
			end
		end
		if (due_descs.size() > n0)
			due_descs[due_descs.size() - 1].last_in_run = 1'b1;
	endfunction

	function automatic pkt_t make_pkt(input logic o, input logic [12:0] p, input logic us,
			input logic [3:0] c, input logic [7:0] sz, input logic [47:0] hd);
		pkt_t t;
		t.op = o;
		t.pid = p;
		t.sync_ok = 1'b1;
		t.unit_start = us;
		t.cc = c;
		t.scrambled = 1'b0;
		t.size = sz;
		t.head = hd;
		t.has_pcr = ($urandom_range(0, 3) == 0);
		t.pcr = 42'({$urandom, $urandom});
		t.index = pkt_count;
		pkt_count = pkt_count + 1;
		return t;
	endfunction

	// Open a PES on the given PID with the given declared length and a random counter.
	function automatic pkt_t start_pes(input logic [12:0] p, input logic [15:0] len,
			input logic [7:0] sz);
		logic [47:0] hd;
		hd = {24'h000001, 8'($urandom), len};
		gen_cc[p[3:0]] = 4'($urandom);
		return make_pkt(OP_PACKET, p, 1'b1, gen_cc[p[3:0]], sz, hd);
	endfunction

	function automatic pkt_t next_pkt(input logic [12:0] p, input logic [7:0] sz);
		gen_cc[p[3:0]] = gen_cc[p[3:0]] + 4'd1;
		return make_pkt(OP_PACKET, p, 1'b0, gen_cc[p[3:0]], sz, {$urandom, 16'($urandom)});
	endfunction

	// Stimulus: directed cases, then mostly well-formed streams with noise.
	initial begin
		pkt_t t;
		logic [12:0] p;
		int k;
		for (int i = 0; i < NUM_PIDS; i++) begin
			pes_ctx[i] = '0;
		end
		// Length reached in the opening packet, on the highest PID.
		pending_pkts.push_back(start_pes(13'h1FFF, 16'd10, 8'd184));
		// Short first packet: header bytes come from the next packets.
		pending_pkts.push_back(start_pes(13'd0, 16'd0, 8'd3));
		pending_pkts.push_back(next_pkt(13'd0, 8'd1));
		pending_pkts.push_back(next_pkt(13'd0, 8'd0));
		t = next_pkt(13'd0, 8'd2);
		t.head = 48'h0000_2200_1111;
		pending_pkts.push_back(t);
		// Duplicate counter is dropped.
		t = pending_pkts[$];
		t.index = pkt_count;
		pkt_count++;
		pending_pkts.push_back(t);
		// Next unit start closes the open PES.
		pending_pkts.push_back(start_pes(13'd0, 16'hFFFF, 8'd255));
		// Flush on open and on absent contexts, then a gap loses sync.
		pending_pkts.push_back(make_pkt(OP_FLUSH, 13'd0, 1'b0, 4'd0, 8'd0, '0));
		pending_pkts.push_back(make_pkt(OP_FLUSH, 13'd5, 1'b0, 4'd0, 8'd0, '0));
		pending_pkts.push_back(start_pes(13'd1, 16'd0, 8'd100));
		gen_cc[1] = gen_cc[1] + 4'd2;
		pending_pkts.push_back(next_pkt(13'd1, 8'd50));
		pending_pkts.push_back(make_pkt(OP_FLUSH, 13'd1, 1'b0, 4'd0, 8'd0, '0));
		// Scrambling and unit start without prefix release the context.
		pending_pkts.push_back(start_pes(13'd2, 16'd0, 8'd10));
		t = next_pkt(13'd2, 8'd10);
		t.scrambled = 1'b1;
		pending_pkts.push_back(t);
		pending_pkts.push_back(start_pes(13'd3, 16'd0, 8'd10));
		pending_pkts.push_back(make_pkt(OP_PACKET, 13'd3, 1'b1, 4'd0, 8'd184,
			48'hFFFF_FFFF_FFFF));
		// Sync byte invalid: ignored.
		t = start_pes(13'd4, 16'd0, 8'd10);
		t.sync_ok = 1'b0;
		pending_pkts.push_back(t);
		// Unit start with the prefix but fewer than three bytes.
		t = start_pes(13'd4, 16'd0, 8'd2);
		pending_pkts.push_back(t);
		// Unbounded PES with many large payloads, then a flush.
		pending_pkts.push_back(start_pes(13'd6, 16'd0, 8'd255));
		for (int i = 0; i < 8; i++)
			pending_pkts.push_back(next_pkt(13'd6, 8'd255));
		pending_pkts.push_back(make_pkt(OP_FLUSH, 13'd6, 1'b0, 4'd0, 8'd0, '0));
		wait (due_descs.size() == 0 && pending_pkts.size() == 0 && !in_valid);
		// Random part: a few PIDs carry well-formed streams.
		for (int n = 0; n < 1500; n++) begin
			k = $urandom_range(0, 99);
			p = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 7));
			if (k < 15)
				t = start_pes(p, ($urandom_range(0, 3) == 0) ? 16'd0 :
					16'($urandom_range(1, 600)), 8'($urandom_range(3, 184)));
			else if (k < 75)
				t = next_pkt(p, ($urandom_range(0, 20) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 184)));
			else if (k < 82)
				t = make_pkt(OP_FLUSH, p, 1'b0, 4'd0, 8'd0, '0);
			else begin
				t = make_pkt(1'($urandom), p, 1'($urandom), 4'($urandom), 8'($urandom),
					{$urandom, 16'($urandom)});
				t.sync_ok = 1'($urandom);
				t.scrambled = ($urandom_range(0, 3) == 0);
				t.index = $urandom;
				if ($urandom_range(0, 1))
					t.head[47:24] = 24'h000001;
			end
			pending_pkts.push_back(t);
			// Long receiver hold-off while input keeps coming.
			if (n == 300)
				hold_req = 1;
			// Sender pause until every descriptor has arrived.
			if (n == 700) begin
				wait (pending_pkts.size() == 0 && !in_valid && due_descs.size() == 0);
			end
			if (n == 1200)
				calm = 1;
			if (pending_pkts.size() > 50)
				wait (pending_pkts.size() < 10);
		end
		stim_done = 1;
	end

	// Reset sequence.
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: presents queued transactions at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_s) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					in_gap <= $urandom_range(1, 11);
					in_valid <= 1'b0;
				end else if (pending_pkts.size() > 0) begin
					t_drv = pending_pkts.pop_front();
					in_valid <= 1'b1;
					op <= t_drv.op;
					pid <= t_drv.pid;
					sync_ok <= t_drv.sync_ok;
					unit_start <= t_drv.unit_start;
					cc <= t_drv.cc;
					scrambled <= t_drv.scrambled;
					payload_size <= t_drv.size;
					payload_head <= t_drv.head;
					has_pcr <= t_drv.has_pcr;
					pcr_in <= t_drv.pcr;
					packet_index <= t_drv.index;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// Receiver stalls: one long hold-off, and random gaps until the calm phase.
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_off <= 400;
				out_ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 12) == 0) begin
				out_gap <= $urandom_range(1, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on accepted inputs and checks accepted descriptors.
	always @(posedge clk) begin
		pkt_t acc;
		desc_t e;
		in_ready_s <= in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				acc = {op, pid, sync_ok, unit_start, cc, scrambled, payload_size,
					payload_head, has_pcr, pcr_in, packet_index};
				predict_descs(acc);
			end
			if (out_valid && out_ready) begin
				if (due_descs.size() == 0) begin
					errors++;
					$display("%0t: unexpected descriptor pid %0d", $time, done_pid);
				end else begin
					e = due_descs.pop_front();
					if ({done_pid, first_index, last_index, pcr_valid, pcr, byte_count,
							end_cause, last_in_run} != e) begin
						errors++;
						$display("%0t: expected pid %0d first %0d last %0d pv %0b pcr %0h %s",
							$time, e.pid, e.first_index, e.last_index, e.pcr_valid,
							e.pcr, $sformatf("bytes %0d cause %0d lr %0b",
							e.byte_count, e.end_cause, e.last_in_run));
						$display("%0t: actual   pid %0d first %0d last %0d pv %0b pcr %0h %s",
							$time, done_pid, first_index, last_index, pcr_valid,
							pcr, $sformatf("bytes %0d cause %0d lr %0b",
							byte_count, end_cause, last_in_run));
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transaction; allows for the clearing pass.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("ts_pes_reassembly_tracker_top verification failed");
			$finish;
		end
	end

	// End of run.
	initial begin
		wait (stim_done && pending_pkts.size() == 0 && !in_valid && due_descs.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && due_descs.size() == 0) begin
			$display("ts_pes_reassembly_tracker_top verification clean");
		end else begin
			$display("ts_pes_reassembly_tracker_top verification failed");
		end
		$finish;
	end

endmodule
